// ===== hdl/tsf_pkg.sv =====
// Package for the fixed-point Taylor sine core: word types, series constants
// and the rounded multiply and accumulate helpers. No dependencies.

package tsf_pkg;

  typedef logic [31:0] word_t;
  typedef logic signed [63:0] prod_t;

  // Register stages from the input transfer to the output register.
  localparam int unsigned Stages = 10;

  typedef struct packed {
    logic [Stages-1:0] en;   // stage register load enables
    logic [Stages-1:0] vld;  // stage valid bits
  } tsf_ctl_t;

  localparam word_t QuadOne   = 32'h4000_0000;
  localparam word_t QuadThree = 32'hC000_0000;
  localparam word_t HalfTurn  = 32'h8000_0000;
  localparam prod_t RoundHalf = 64'sh0000_0000_8000_0000;

  localparam word_t CoefC1  = 32'd1686629713;
  localparam word_t CoefC3  = 32'd1431655765;
  localparam word_t CoefC5  = 32'd572662306;
  localparam word_t CoefC7  = 32'd109078534;
  localparam word_t CoefC9  = 32'd12119837;
  localparam word_t CoefC11 = 32'd881443;

  // The two middle quadrants are mirrored about a quarter turn.
  function automatic word_t fold_phase(word_t ph);
    word_t ang;
    if (ph >= QuadThree || ph < QuadOne) begin
      ang = ph;
    end else begin
      ang = HalfTurn - ph;
    end
    return ang;
  endfunction

  function automatic prod_t sprod(word_t a, word_t b);
    return $signed(a) * $signed(b);
  endfunction

  // High half of the signed product with round to nearest.
  function automatic word_t mulr(word_t a, word_t b);
    prod_t r;
    r = sprod(a, b) + RoundHalf;
    return r[63:32];
  endfunction

  function automatic word_t acc_add(word_t s, prod_t p);
    prod_t r;
    r = {s, 32'h0} + p + RoundHalf;
    return r[63:32];
  endfunction

  function automatic word_t acc_sub(word_t s, prod_t p);
    prod_t r;
    r = {s, 32'h0} - p + RoundHalf;
    return r[63:32];
  endfunction

endpackage

// ===== hdl/tsf_if.sv =====
// Valid/ready channel interfaces for the phase input and the sine output.
// Depends on tsf_pkg for the word type.

interface tsf_phase_if;
  logic          valid;
  logic          ready;
  tsf_pkg::word_t phase;

  modport source (output valid, output phase, input ready);
  modport sink   (input valid, input phase, output ready);
endinterface

interface tsf_sine_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  sine_value;

  modport source (output valid, output sine_value, input ready);
  modport sink   (input valid, input sine_value, output ready);
endinterface

// ===== hdl/tsf_pipe_ctl.sv =====
// Valid bits and load enables of the sine pipeline. A stage loads when it is
// empty or when the stage after it moves on, so bubbles close up under stall.
// Depends on tsf_pkg.

module tsf_pipe_ctl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output tsf_pkg::tsf_ctl_t ctl_o
);
  import tsf_pkg::*;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_d;
  logic [Stages-1:0] en;

  always_comb begin
    en[Stages-1] = !vld_q[Stages-1] || out_ready_i;
    for (int i = Stages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < Stages; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = en[0];
  assign ctl_o.en   = en;
  assign ctl_o.vld  = vld_q;

endmodule

// ===== hdl/taylor_sine_fixed_point_core.sv =====
// Top level of the fixed-point Taylor sine core.
// Depends on tsf_pkg, tsf_if.sv and tsf_pipe_ctl.
//
// Usage:
//   phase_i  (sink)  : one 32-bit unsigned phase per transfer, full circle 2^32.
//   sine_o   (source): one signed Q1.31 sine per input transfer, in order.
//   The datapath is a ten-stage pipeline: the folded angle, then x1, x2 and x3,
//   then one odd power and one coefficient product per stage while the series
//   sum follows a stage behind, and finally the output register.
//   Throughput is one item per cycle while the receiver takes results; the
//   32x32 multipliers in the stages between the fold and the output register
//   set the stage depth.
//   Reset clears only the valid bits; the datapath registers are not reset.
//   When the receiver stalls, the output register holds its result and the
//   empty stages ahead of it keep filling; input ready falls only once every
//   stage holds an item. Nothing is dropped or repeated.

module taylor_sine_fixed_point_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  tsf_phase_if.sink  phase_i,
  tsf_sine_if.source sine_o
);
  import tsf_pkg::*;

  tsf_ctl_t ctl;

  tsf_pipe_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (phase_i.valid),
    .in_ready_o (phase_i.ready),
    .out_ready_i(sine_o.ready),
    .ctl_o      (ctl)
  );

  word_t ang_q;
  word_t x1_s2_q;
  word_t x1_s3_q, x2_s3_q;
  word_t x1_s4_q, x2_s4_q, x3_s4_q;
  word_t x1_s5_q, x2_s5_q, x5_s5_q;
  prod_t p3_s5_q;
  word_t acc_s6_q, x2_s6_q, x7_s6_q;
  prod_t p5_s6_q;
  word_t acc_s7_q, x2_s7_q, x9_s7_q;
  prod_t p7_s7_q;
  word_t acc_s8_q, x11_s8_q;
  prod_t p9_s8_q;
  word_t acc_s9_q;
  prod_t p11_s9_q;
  word_t sine_q;
  word_t acc_last;

  always_ff @(posedge clk_i) begin
    if (ctl.en[0]) begin
      ang_q <= fold_phase(phase_i.phase);
    end
    if (ctl.en[1]) begin
      x1_s2_q <= mulr(ang_q, CoefC1) << 2;
    end
    if (ctl.en[2]) begin
      x2_s3_q <= mulr(x1_s2_q, x1_s2_q) << 1;
      x1_s3_q <= x1_s2_q;
    end
    if (ctl.en[3]) begin
      x3_s4_q <= mulr(x2_s3_q, x1_s3_q) << 2;
      x2_s4_q <= x2_s3_q;
      x1_s4_q <= x1_s3_q;
    end
    if (ctl.en[4]) begin
      x5_s5_q <= mulr(x3_s4_q, x2_s4_q);
      p3_s5_q <= sprod(x3_s4_q, CoefC3);
      x2_s5_q <= x2_s4_q;
      x1_s5_q <= x1_s4_q;
    end
    if (ctl.en[5]) begin
      acc_s6_q <= acc_sub(x1_s5_q, p3_s5_q);
      x7_s6_q  <= mulr(x5_s5_q, x2_s5_q);
      p5_s6_q  <= sprod(x5_s5_q, CoefC5);
      x2_s6_q  <= x2_s5_q;
    end
    if (ctl.en[6]) begin
      acc_s7_q <= acc_add(acc_s6_q, p5_s6_q);
      x9_s7_q  <= mulr(x7_s6_q, x2_s6_q);
      p7_s7_q  <= sprod(x7_s6_q, CoefC7);
      x2_s7_q  <= x2_s6_q;
    end
    if (ctl.en[7]) begin
      acc_s8_q <= acc_sub(acc_s7_q, p7_s7_q);
      x11_s8_q <= mulr(x9_s7_q, x2_s7_q);
      p9_s8_q  <= sprod(x9_s7_q, CoefC9);
    end
    if (ctl.en[8]) begin
      acc_s9_q <= acc_add(acc_s8_q, p9_s8_q);
      p11_s9_q <= sprod(x11_s8_q, CoefC11);
    end
    if (ctl.en[9]) begin
      sine_q <= acc_last << 1;
    end
  end

  assign acc_last = acc_sub(acc_s9_q, p11_s9_q);

  assign sine_o.valid      = ctl.vld[Stages-1];
  assign sine_o.sine_value = $signed(sine_q);

endmodule

// ===== hdl/tsf_checker.sv =====
// Port-level checks of the Taylor sine core and their bind to the top level.
// Depends only on the top level's ports.

module tsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_sine_i
);

  // A result that is not taken stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sine_i))
    else $error("result changed while stalled");

  // Input may only stall when the output register holds a stalled result.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_i) |-> in_ready_i)
    else $error("input stalled although the pipeline can advance");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result offered right after reset");

endmodule

bind taylor_sine_fixed_point_core tsf_checker u_tsf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (phase_i.ready),
  .out_valid_i(sine_o.valid),
  .out_ready_i(sine_o.ready),
  .out_sine_i (sine_o.sine_value)
);
